// File: rtl/core/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Types, register map and constants of the charge current regulator.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 15;
  localparam int SHIFT_W  = 5;
  localparam int TPM_W    = 20;
  localparam int DUTY_W   = 13;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 32;

  localparam logic [SUM_W-1:0]   START_POWER   = 32'd1300000;
  localparam logic [DUTY_W-1:0]  DUTY_MAX      = 13'd7000;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 5'd10;
  localparam logic [TPM_W-1:0]   TPM_RESET     = 20'd3600;

  typedef enum logic [1:0] {
    RUN_STOP      = 2'd0,
    RUN_CHARGE    = 2'd1,
    RUN_DISCHARGE = 2'd2,
    RUN_PAUSE     = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_RESTART = 1'b0,
    KIND_TICK    = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_RUN_MODE       = 3'd0,
    REG_TARGET_CURRENT = 3'd1,
    REG_PROP_GAIN      = 3'd2,
    REG_INTEG_GAIN     = 3'd3,
    REG_SHIFT_BITS     = 3'd4,
    REG_TICKS_PER_MAH  = 3'd5
  } reg_index_t;

endpackage

// File: rtl/core/ccr_meas_if.sv
// ----------------------------------------------------------------------------
// ccr_meas_if
// Measurement channel: restart or current sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccr_meas_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [ccr_pkg::SAMPLE_W-1:0] measured_current;

  modport source (output valid, output kind, output measured_current, input ready);
  modport sink (input valid, input kind, input measured_current, output ready);
endinterface

// File: rtl/core/ccr_status_if.sv
// ----------------------------------------------------------------------------
// ccr_status_if
// Result channel: applied duty and milliamp hour counts, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccr_status_if;
  logic                         valid;
  logic                         ready;
  logic [ccr_pkg::DUTY_W-1:0]   duty;
  logic                         duty_updated;
  logic [ccr_pkg::COUNT_W-1:0]  chg_mah;
  logic [ccr_pkg::COUNT_W-1:0]  dchg_mah;

  modport source (output valid, output duty, output duty_updated, output chg_mah,
                  output dchg_mah, input ready);
  modport sink (input valid, input duty, input duty_updated, input chg_mah,
                input dchg_mah, output ready);
endinterface

// File: rtl/core/charge_current_regulator.sv
// ----------------------------------------------------------------------------
// charge_current_regulator
// One charger channel: incremental PI current loop, PWM duty, mAh counters.
// meas carries restart transactions and signed current samples; status returns
// one transaction per measurement: duty, duty_updated and both mAh counts.
// Registers are written over the APB port (byte address 4*index); the user
// must write them only while idle; the block itself does not enforce it. A meas
// transaction passes an input register, then a result register, before
// status.valid rises. One transaction per cycle is sustained while status is
// ready. The rate is set by the power sum loop, whose multiply, add, rounding
// shift and clamp are combinational in the compute stage. Reset loads the
// register defaults and the controller start power, clears the counters and
// the duty, and empties both stages. When status is stalled the result is
// held; one more transaction waits in the input stage, then meas.ready drops.
// ----------------------------------------------------------------------------
module charge_current_regulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ccr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ccr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ccr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  ccr_meas_if.sink                          meas,
  ccr_status_if.source                      status
);

  // configuration registers
  ccr_pkg::mode_t                   run_mode;
  logic [ccr_pkg::GAIN_W-1:0]       target_current;
  logic [ccr_pkg::GAIN_W-1:0]       prop_gain;
  logic [ccr_pkg::GAIN_W-1:0]       integ_gain;
  logic [ccr_pkg::SHIFT_W-1:0]      shift_bits;
  logic [ccr_pkg::TPM_W-1:0]        ticks_per_mah;

  // input stage
  logic                                s1_valid;
  logic                                s1_kind;
  logic signed [ccr_pkg::SAMPLE_W-1:0] s1_sample;
  logic                                s1_advance;

  // controller and counter state
  logic [ccr_pkg::SUM_W-1:0]           power_sum;
  logic [ccr_pkg::SUM_W-1:0]           held_power;
  logic signed [ccr_pkg::SAMPLE_W-1:0] older_sample;
  logic signed [ccr_pkg::SAMPLE_W-1:0] last_sample;
  logic                                overshoot_seen;
  logic [ccr_pkg::SUM_W-1:0]           charge_accum;
  logic [ccr_pkg::SUM_W-1:0]           discharge_accum;
  logic [ccr_pkg::COUNT_W-1:0]         charge_count;
  logic [ccr_pkg::COUNT_W-1:0]         discharge_count;
  logic [ccr_pkg::DUTY_W-1:0]          applied_duty;
  logic                                out_valid;
  logic                                out_updated;

  // compute stage
  logic                                cfg_write;
  ccr_pkg::reg_index_t                 cfg_index;
  logic signed [ccr_pkg::SAMPLE_W:0]   err;
  logic signed [ccr_pkg::SAMPLE_W:0]   diff;
  logic signed [ccr_pkg::SAMPLE_W:0]   p_operand;
  logic signed [ccr_pkg::SUM_W:0]      prod_p;
  logic signed [ccr_pkg::SUM_W:0]      prod_i;
  logic                                direct;
  logic                                snap;
  logic [ccr_pkg::SUM_W-1:0]           base;
  logic [ccr_pkg::SUM_W-1:0]           power_sum_next;
  logic [ccr_pkg::SUM_W-1:0]           round_term;
  logic [ccr_pkg::SUM_W-1:0]           rounded;
  logic signed [ccr_pkg::SUM_W-1:0]    shifted;
  logic [ccr_pkg::DUTY_W-1:0]          duty_next;
  logic [ccr_pkg::SUM_W-1:0]           sample_ext;
  logic [ccr_pkg::SUM_W-1:0]           tpm_ext;
  logic [ccr_pkg::SUM_W-1:0]           accum_sel;
  logic [ccr_pkg::SUM_W-1:0]           accum_sum;
  logic                                mah_hit;
  logic [ccr_pkg::SUM_W-1:0]           accum_next;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = ccr_pkg::reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= ccr_pkg::RUN_STOP;
      target_current <= '0;
      prop_gain      <= '0;
      integ_gain     <= '0;
      shift_bits     <= ccr_pkg::SHIFT_RESET;
      ticks_per_mah  <= ccr_pkg::TPM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ccr_pkg::REG_RUN_MODE:       run_mode       <= ccr_pkg::mode_t'(pwdata[1:0]);
        ccr_pkg::REG_TARGET_CURRENT: target_current <= pwdata[ccr_pkg::GAIN_W-1:0];
        ccr_pkg::REG_PROP_GAIN:      prop_gain      <= pwdata[ccr_pkg::GAIN_W-1:0];
        ccr_pkg::REG_INTEG_GAIN:     integ_gain     <= pwdata[ccr_pkg::GAIN_W-1:0];
        ccr_pkg::REG_SHIFT_BITS:     shift_bits     <= pwdata[ccr_pkg::SHIFT_W-1:0];
        ccr_pkg::REG_TICKS_PER_MAH:  ticks_per_mah  <= pwdata[ccr_pkg::TPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_index)
      ccr_pkg::REG_RUN_MODE:       prdata = {30'd0, run_mode};
      ccr_pkg::REG_TARGET_CURRENT: prdata = {17'd0, target_current};
      ccr_pkg::REG_PROP_GAIN:      prdata = {17'd0, prop_gain};
      ccr_pkg::REG_INTEG_GAIN:     prdata = {17'd0, integ_gain};
      ccr_pkg::REG_SHIFT_BITS:     prdata = {27'd0, shift_bits};
      ccr_pkg::REG_TICKS_PER_MAH:  prdata = {12'd0, ticks_per_mah};
      default:                     prdata = '0;
    endcase
  end

  // handshake
  assign s1_advance = s1_valid && (!out_valid || status.ready);
  assign meas.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (meas.ready) begin
      s1_valid <= meas.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (meas.valid && meas.ready) begin
      s1_kind   <= meas.kind;
      s1_sample <= meas.measured_current;
    end
  end

  // pi step
  always_comb begin
    err       = $signed({2'b00, target_current}) - $signed({s1_sample[15], s1_sample});
    diff      = $signed({last_sample[15], last_sample}) - $signed({s1_sample[15], s1_sample});
    direct    = older_sample[15];
    p_operand = direct ? err : diff;
    prod_p    = $signed({1'b0, prop_gain}) * p_operand;
    prod_i    = $signed({1'b0, integ_gain}) * err;
    snap      = !direct && !overshoot_seen && (s1_sample > $signed({1'b0, target_current}));
    if (direct) begin
      base = '0;
    end else if (snap) begin
      base = held_power;
    end else begin
      base = power_sum;
    end
    power_sum_next = base + prod_p[ccr_pkg::SUM_W-1:0] + prod_i[ccr_pkg::SUM_W-1:0];
    if (shift_bits == '0) begin
      round_term = '0;
    end else begin
      round_term = 32'd1 << (shift_bits - 5'd1);
    end
    rounded = power_sum_next + round_term;
    shifted = $signed(rounded) >>> shift_bits;
    if (shifted[ccr_pkg::SUM_W-1]) begin
      duty_next = '0;
    end else if (shifted > $signed({19'd0, ccr_pkg::DUTY_MAX})) begin
      duty_next = ccr_pkg::DUTY_MAX;
    end else begin
      duty_next = shifted[ccr_pkg::DUTY_W-1:0];
    end
  end

  // milliamp hour accumulation, shared by charge and discharge
  always_comb begin
    sample_ext = {{(ccr_pkg::SUM_W-ccr_pkg::SAMPLE_W){s1_sample[15]}}, s1_sample};
    tpm_ext    = {{(ccr_pkg::SUM_W-ccr_pkg::TPM_W){1'b0}}, ticks_per_mah};
    accum_sel  = (run_mode == ccr_pkg::RUN_CHARGE) ? charge_accum : discharge_accum;
    accum_sum  = accum_sel + sample_ext;
    mah_hit    = $signed(accum_sum) >= $signed(tpm_ext);
    accum_next = mah_hit ? accum_sum - tpm_ext : accum_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_sum       <= ccr_pkg::START_POWER;
      held_power      <= ccr_pkg::START_POWER;
      older_sample    <= '0;
      last_sample     <= '0;
      overshoot_seen  <= 1'b0;
      charge_accum    <= '0;
      discharge_accum <= '0;
      charge_count    <= '0;
      discharge_count <= '0;
      applied_duty    <= '0;
      out_updated     <= 1'b0;
    end else if (s1_advance) begin
      out_updated <= 1'b0;
      if (s1_kind == ccr_pkg::KIND_RESTART) begin
        power_sum      <= ccr_pkg::START_POWER;
        held_power     <= ccr_pkg::START_POWER;
        older_sample   <= '0;
        last_sample    <= '0;
        overshoot_seen <= 1'b0;
        applied_duty   <= '0;
        out_updated    <= 1'b1;
      end else begin
        case (run_mode)
          ccr_pkg::RUN_CHARGE: begin
            charge_accum <= accum_next;
            if (mah_hit) begin
              charge_count <= charge_count + 16'd1;
            end
            power_sum <= power_sum_next;
            if (!direct) begin
              held_power <= power_sum_next;
            end
            if (snap) begin
              overshoot_seen <= 1'b1;
            end
            older_sample <= last_sample;
            last_sample  <= s1_sample;
            applied_duty <= duty_next;
            out_updated  <= 1'b1;
          end
          ccr_pkg::RUN_DISCHARGE: begin
            discharge_accum <= accum_next;
            if (mah_hit) begin
              discharge_count <= discharge_count + 16'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.valid         = out_valid;
  assign status.duty          = applied_duty;
  assign status.duty_updated  = out_updated;
  assign status.chg_mah       = charge_count;
  assign status.dchg_mah      = discharge_count;

`ifndef SYNTHESIS
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    applied_duty <= ccr_pkg::DUTY_MAX)
    else $error("duty above limit");

  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_kind == ccr_pkg::KIND_RESTART
    |=> status.valid && status.duty == '0 && status.duty_updated)
    else $error("restart did not clear duty");

  a_idle_mode_holds: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_kind == ccr_pkg::KIND_TICK
    && (run_mode == ccr_pkg::RUN_STOP || run_mode == ccr_pkg::RUN_PAUSE)
    |=> $stable(power_sum) && $stable(applied_duty) && !status.duty_updated
        && $stable(charge_count) && $stable(discharge_count))
    else $error("state changed in stop or pause");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    charge_count != $past(charge_count)
    |-> charge_count == 16'($past(charge_count) + 16'd1))
    else $error("charge count jumped");
`endif

endmodule

// File: tb/charge_current_regulator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// charge_current_regulator_tb
// Self-checking bench for the charge current regulator. Restart and current
// sample transactions go in on the measurement channel. A cycle-free software
// copy of the PI loop and the mAh counters predicts each status transaction,
// and every field of it is checked in order. Registers are set over APB
// between phases and read back. Random idle and stall bursts hit both sides,
// and the last phase streams back to back.
// ----------------------------------------------------------------------------
module charge_current_regulator_tb;

  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    logic [ccr_pkg::DUTY_W-1:0]  duty;
    logic                        updated;
    logic [ccr_pkg::COUNT_W-1:0] chg_mah;
    logic [ccr_pkg::COUNT_W-1:0] dchg_mah;
  } status_t;

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ccr_pkg::APB_ADDR_W-1:0] paddr;
  logic [ccr_pkg::APB_DATA_W-1:0] pwdata;
  logic [ccr_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  ccr_meas_if   meas_ch();
  ccr_status_if status_ch();

  charge_current_regulator DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .meas    (meas_ch),
    .status  (status_ch)
  );

  // register copy
  ccr_pkg::mode_t cfg_mode;
  int             cfg_target, cfg_kp, cfg_ki, cfg_shift, cfg_tpm;

  // loop and counter state
  int                          power_sum, held_power, error_sum, older_i, last_i;
  bit                          snapped;
  int                          charge_acc, discharge_acc;
  logic [ccr_pkg::COUNT_W-1:0] charge_cnt, discharge_cnt;
  logic [ccr_pkg::DUTY_W-1:0]  duty_now;

  status_t due_status[$];
  bit      idle_on;
  int      mismatches, n_results, n_restart, n_charge, n_discharge, n_held;
  int      n_snap, n_direct, n_floor, n_ceiling, n_writes;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH t=%0t %s: got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic void restart_loop();
    power_sum  = int'(ccr_pkg::START_POWER);
    held_power = int'(ccr_pkg::START_POWER);
    error_sum  = 0;
    older_i    = 0;
    last_i     = 0;
    snapped    = 1'b0;
  endfunction

  function automatic void reset_model();
    cfg_mode      = ccr_pkg::RUN_STOP;
    cfg_target    = 0;
    cfg_kp        = 0;
    cfg_ki        = 0;
    cfg_shift     = int'(ccr_pkg::SHIFT_RESET);
    cfg_tpm       = int'(ccr_pkg::TPM_RESET);
    restart_loop();
    charge_acc    = 0;
    discharge_acc = 0;
    charge_cnt    = '0;
    discharge_cnt = '0;
    duty_now      = '0;
  endfunction

  function automatic void set_cfg(input ccr_pkg::reg_index_t idx, input logic [31:0] val);
    case (idx)
      ccr_pkg::REG_RUN_MODE:       cfg_mode   = ccr_pkg::mode_t'(val[1:0]);
      ccr_pkg::REG_TARGET_CURRENT: cfg_target = int'(val[ccr_pkg::GAIN_W-1:0]);
      ccr_pkg::REG_PROP_GAIN:      cfg_kp     = int'(val[ccr_pkg::GAIN_W-1:0]);
      ccr_pkg::REG_INTEG_GAIN:     cfg_ki     = int'(val[ccr_pkg::GAIN_W-1:0]);
      ccr_pkg::REG_SHIFT_BITS:     cfg_shift  = int'(val[ccr_pkg::SHIFT_W-1:0]);
      ccr_pkg::REG_TICKS_PER_MAH:  cfg_tpm    = int'(val[ccr_pkg::TPM_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input ccr_pkg::reg_index_t idx);
    case (idx)
      ccr_pkg::REG_RUN_MODE:       return 32'(cfg_mode);
      ccr_pkg::REG_TARGET_CURRENT: return cfg_target;
      ccr_pkg::REG_PROP_GAIN:      return cfg_kp;
      ccr_pkg::REG_INTEG_GAIN:     return cfg_ki;
      ccr_pkg::REG_SHIFT_BITS:     return cfg_shift;
      ccr_pkg::REG_TICKS_PER_MAH:  return cfg_tpm;
      default:                     return '0;
    endcase
  endfunction

  function automatic void count_mah(inout int acc, inout logic [ccr_pkg::COUNT_W-1:0] cnt,
                                    input int s);
    acc += s;
    if (acc >= cfg_tpm) begin
      cnt++;
      acc -= cfg_tpm;
    end
  endfunction

  // incremental pi step, rounding shift and clamp to the duty range
  function automatic logic [ccr_pkg::DUTY_W-1:0] regulate(input int s);
    int err, v, d;
    err = cfg_target - s;
    if (older_i < 0) begin
      error_sum = err;
      power_sum = cfg_kp * err + cfg_ki * error_sum;
      n_direct++;
    end else begin
      if (!snapped && s > cfg_target) begin
        error_sum = 0;
        power_sum = held_power;
        snapped   = 1'b1;
        n_snap++;
      end
      power_sum += cfg_kp * (last_i - s) + cfg_ki * err;
      held_power = power_sum;
    end
    older_i = last_i;
    last_i  = s;
    v = power_sum;
    if (cfg_shift > 0) v += 1 << (cfg_shift - 1);
    d = v >>> cfg_shift;
    if (d <= 0) begin
      d = 0;
      n_floor++;
    end else if (d >= int'(ccr_pkg::DUTY_MAX)) begin
      d = int'(ccr_pkg::DUTY_MAX);
      n_ceiling++;
    end
    return d[ccr_pkg::DUTY_W-1:0];
  endfunction

  function automatic status_t next_status(input ccr_pkg::kind_t k,
                                          input logic signed [ccr_pkg::SAMPLE_W-1:0] cur);
    status_t r;
    int      s;
    s = cur;
    r.updated = 1'b0;
    if (k == ccr_pkg::KIND_RESTART) begin
      restart_loop();
      duty_now  = '0;
      r.updated = 1'b1;
      n_restart++;
    end else if (cfg_mode == ccr_pkg::RUN_CHARGE) begin
      count_mah(charge_acc, charge_cnt, s);
      duty_now  = regulate(s);
      r.updated = 1'b1;
      n_charge++;
    end else if (cfg_mode == ccr_pkg::RUN_DISCHARGE) begin
      count_mah(discharge_acc, discharge_cnt, s);
      n_discharge++;
    end else begin
      n_held++;
    end
    r.duty     = duty_now;
    r.chg_mah  = charge_cnt;
    r.dchg_mah = discharge_cnt;
    return r;
  endfunction

  function automatic logic signed [ccr_pkg::SAMPLE_W-1:0] rand_current();
    logic signed [ccr_pkg::SAMPLE_W-1:0] r;
    int                                  c;
    case ($urandom_range(0, 9))
      0: r = ccr_pkg::SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       r = 16'sh8000;
          1:       r = 16'sh7FFF;
          2:       r = 16'sh0000;
          default: r = 16'shFFFF;
        endcase
      end
      default: begin
        c = cfg_target + int'($urandom_range(0, 800)) - 400;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        r = c[ccr_pkg::SAMPLE_W-1:0];
      end
    endcase
    return r;
  endfunction

  task automatic apb_xfer(input bit wr, input ccr_pkg::reg_index_t idx,
                          input logic [31:0] wd, output logic [31:0] rd);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    meas_ch.valid <= 1'b0;
    do @(posedge clk); while (due_status.size() != 0);
  endtask

  task automatic write_reg(input ccr_pkg::reg_index_t idx, input logic [31:0] val);
    logic [31:0] rd;
    settle();
    set_cfg(idx, val);
    n_writes++;
    apb_xfer(1'b1, idx, val, rd);
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx))
      report_mismatch({"readback of ", idx.name()}, rd, reg_value(idx));
  endtask

  task automatic push_item(input ccr_pkg::kind_t k,
                           input logic signed [ccr_pkg::SAMPLE_W-1:0] cur);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      meas_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    meas_ch.valid            <= 1'b1;
    meas_ch.kind             <= k;
    meas_ch.measured_current <= cur;
    do @(posedge clk); while (!meas_ch.ready);
    due_status.push_back(next_status(k, cur));
  endtask

  task automatic test_reset_state();
    ccr_pkg::reg_index_t idx;
    logic [31:0]         rd;
    idx = idx.first();
    repeat (idx.num()) begin
      apb_xfer(1'b0, idx, '0, rd);
      if (rd !== reg_value(idx))
        report_mismatch({"reset value of ", idx.name()}, rd, reg_value(idx));
      idx = idx.next();
    end
    push_item(ccr_pkg::KIND_TICK, 16'sh7FFF);
    push_item(ccr_pkg::KIND_TICK, 16'sh8000);
    push_item(ccr_pkg::KIND_RESTART, 16'sh0000);
  endtask

  task automatic test_directed();
    write_reg(ccr_pkg::REG_TARGET_CURRENT, 1000);
    write_reg(ccr_pkg::REG_PROP_GAIN, 200);
    write_reg(ccr_pkg::REG_INTEG_GAIN, 50);
    write_reg(ccr_pkg::REG_RUN_MODE, ccr_pkg::RUN_CHARGE);
    push_item(ccr_pkg::KIND_TICK, 16'sd500);
    push_item(ccr_pkg::KIND_TICK, 16'sd900);
    push_item(ccr_pkg::KIND_TICK, 16'sd1200);
    push_item(ccr_pkg::KIND_TICK, 16'sd1100);
    push_item(ccr_pkg::KIND_TICK, 16'sh8000);
    push_item(ccr_pkg::KIND_TICK, 16'sh7FFF);
    push_item(ccr_pkg::KIND_TICK, 16'sd0);
    push_item(ccr_pkg::KIND_TICK, 16'shFFFF);
    push_item(ccr_pkg::KIND_RESTART, 16'sh7FFF);
    push_item(ccr_pkg::KIND_TICK, 16'sd1000);

    write_reg(ccr_pkg::REG_RUN_MODE, ccr_pkg::RUN_PAUSE);
    push_item(ccr_pkg::KIND_TICK, 16'sd300);
    write_reg(ccr_pkg::REG_RUN_MODE, ccr_pkg::RUN_STOP);
    push_item(ccr_pkg::KIND_TICK, 16'sd300);

    write_reg(ccr_pkg::REG_TICKS_PER_MAH, 40000);
    write_reg(ccr_pkg::REG_RUN_MODE, ccr_pkg::RUN_DISCHARGE);
    push_item(ccr_pkg::KIND_TICK, 16'sh7FFF);
    push_item(ccr_pkg::KIND_TICK, 16'sh7FFF);
    push_item(ccr_pkg::KIND_TICK, 16'sh8000);

    // no rounding, every non-negative accumulator counts
    write_reg(ccr_pkg::REG_SHIFT_BITS, 0);
    write_reg(ccr_pkg::REG_TICKS_PER_MAH, 0);
    write_reg(ccr_pkg::REG_RUN_MODE, ccr_pkg::RUN_CHARGE);
    push_item(ccr_pkg::KIND_TICK, 16'sd5);
    push_item(ccr_pkg::KIND_TICK, -16'sd3);
    push_item(ccr_pkg::KIND_TICK, 16'sh7FFF);

    write_reg(ccr_pkg::REG_SHIFT_BITS, 31);
    write_reg(ccr_pkg::REG_TICKS_PER_MAH, 20'hFFFFF);
    write_reg(ccr_pkg::REG_TARGET_CURRENT, 15'h7FFF);
    write_reg(ccr_pkg::REG_PROP_GAIN, 15'h7FFF);
    write_reg(ccr_pkg::REG_INTEG_GAIN, 15'h7FFF);
    push_item(ccr_pkg::KIND_TICK, 16'sh8000);
    push_item(ccr_pkg::KIND_TICK, 16'sh7FFF);
    push_item(ccr_pkg::KIND_TICK, 16'sd0);
  endtask

  task automatic test_random_phases();
    int             n_items;
    ccr_pkg::mode_t m;
    for (int p = 0; p < 8; p++) begin
      write_reg(ccr_pkg::REG_SHIFT_BITS, (p == 0) ? 0 : (p == 1) ? 31 : $urandom_range(6, 14));
      case (p % 4)
        0:       write_reg(ccr_pkg::REG_TICKS_PER_MAH, 0);
        1:       write_reg(ccr_pkg::REG_TICKS_PER_MAH, 20'hFFFFF);
        2:       write_reg(ccr_pkg::REG_TICKS_PER_MAH, $urandom_range(1, 200));
        default: write_reg(ccr_pkg::REG_TICKS_PER_MAH, $urandom_range(1000, 8000));
      endcase
      write_reg(ccr_pkg::REG_TARGET_CURRENT, ($urandom_range(0, 9) == 0) ?
                $urandom_range(0, 32767) : $urandom_range(100, 3000));
      write_reg(ccr_pkg::REG_PROP_GAIN, ($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 32767) : $urandom_range(0, 1500));
      write_reg(ccr_pkg::REG_INTEG_GAIN, ($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 32767) : $urandom_range(0, 1500));
      if (p == 3) m = ccr_pkg::RUN_DISCHARGE;
      else if (p == 6) m = $urandom_range(0, 1) ? ccr_pkg::RUN_STOP : ccr_pkg::RUN_PAUSE;
      else m = ccr_pkg::RUN_CHARGE;
      write_reg(ccr_pkg::REG_RUN_MODE, m);
      n_items = (m == ccr_pkg::RUN_STOP || m == ccr_pkg::RUN_PAUSE) ? 15 : 60;
      repeat (n_items)
        push_item(($urandom_range(0, 15) == 0) ? ccr_pkg::KIND_RESTART : ccr_pkg::KIND_TICK,
                  rand_current());
    end
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    write_reg(ccr_pkg::REG_SHIFT_BITS, 10);
    write_reg(ccr_pkg::REG_TICKS_PER_MAH, 3600);
    write_reg(ccr_pkg::REG_TARGET_CURRENT, 1500);
    write_reg(ccr_pkg::REG_PROP_GAIN, 300);
    write_reg(ccr_pkg::REG_INTEG_GAIN, 100);
    write_reg(ccr_pkg::REG_RUN_MODE, ccr_pkg::RUN_CHARGE);
    repeat (100)
      push_item(($urandom_range(0, 19) == 0) ? ccr_pkg::KIND_RESTART : ccr_pkg::KIND_TICK,
                rand_current());
  endtask

  // status sink with random stall bursts
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        status_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      status_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : status_check
    status_t want;
    if (!rst && status_ch.valid === 1'b1 && status_ch.ready === 1'b1) begin
      n_results++;
      if (due_status.size() == 0) begin
        report_mismatch("status transaction with nothing pending", status_ch.duty, 0);
      end else begin
        want = due_status.pop_front();
        if (status_ch.duty !== want.duty)
          report_mismatch("duty", status_ch.duty, want.duty);
        if (status_ch.duty_updated !== want.updated)
          report_mismatch("duty_updated", status_ch.duty_updated, want.updated);
        if (status_ch.chg_mah !== want.chg_mah)
          report_mismatch("chg_mah", status_ch.chg_mah, want.chg_mah);
        if (status_ch.dchg_mah !== want.dchg_mah)
          report_mismatch("dchg_mah", status_ch.dchg_mah, want.dchg_mah);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst === 1'b1 || (meas_ch.valid === 1'b1 && meas_ch.ready === 1'b1) ||
          (status_ch.valid === 1'b1 && status_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results pending",
             QUIET_LIMIT, due_status.size());
    $display("charge_current_regulator_tb: FAIL");
    $finish;
  end

  initial begin
    rst                      <= 1'b1;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    meas_ch.valid            <= 1'b0;
    meas_ch.kind             <= ccr_pkg::KIND_TICK;
    meas_ch.measured_current <= '0;
    idle_on = 1'b1;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed();
    test_random_phases();
    test_streaming();

    settle();
    repeat (4) @(posedge clk);
    $display("covered %0d status transactions: %0d restarts, %0d charge, %0d discharge, %0d held",
             n_results, n_restart, n_charge, n_discharge, n_held);
    $display("  %0d register writes, %0d snaps, %0d direct steps, clamps %0d/%0d, %0d mismatches",
             n_writes, n_snap, n_direct, n_floor, n_ceiling, mismatches);
    if (mismatches == 0 && due_status.size() == 0) begin
      $display("charge_current_regulator_tb: PASS");
    end else begin
      $display("charge_current_regulator_tb: FAIL");
    end
    $finish;
  end

endmodule
